// File: src/ssi_pkg.sv
`timescale 1ns / 1ps

package ssi_pkg;

  localparam int CW  = 16;          // coordinate width, Q12.4
  localparam int VW  = CW + 1;      // direction / offset width
  localparam int PW  = 2 * VW;      // cross product width
  localparam int QW  = 24;          // quotient width, Q8.16 parameter
  localparam int FRW = 16;          // fraction bits of a parameter
  localparam int NW  = PW + VW;     // dividend magnitude width
  localparam int RW  = PW + QW - 1; // widest shifted divisor
  localparam int SW  = CW + 10;     // point sum width

  localparam int NDIV = 4;          // first param, second param, x, y
  localparam int DT   = 0;
  localparam int DU   = 1;
  localparam int DX   = 2;
  localparam int DY   = 3;

  localparam logic signed [QW-1:0] PMAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] PMIN = {1'b1, {(QW-1){1'b0}}};
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic signed [CW-1:0]       ax;
    logic signed [CW-1:0]       ay;
    logic signed [PW-1:0]       den;
    logic                       hit;
    logic                       zero;
    logic [PW-1:0]              dmag;
    logic [NDIV-1:0]            neg;
    logic [NDIV-1:0]            ovf;
    logic [NDIV-1:0][NW-1:0]    rem;
    logic [NDIV-1:0][QW-1:0]    quo;
  } div_t;

endpackage

// File: src/segment_segment_intersect.sv
`timescale 1ns / 1ps
// throughput: one request per cycle without stalls; a quotient bit per stage in four
//   parallel restoring dividers (24 stages) behind seven stages of products and setup
// stalls hold only full stages, so bubbles close up under a busy output
// reset clears every stage valid bit; data registers are not reset

module segment_segment_intersect
  import ssi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CW-1:0] first_start_x,
  input  logic signed [CW-1:0] first_start_y,
  input  logic signed [CW-1:0] first_end_x,
  input  logic signed [CW-1:0] first_end_y,
  input  logic signed [CW-1:0] second_start_x,
  input  logic signed [CW-1:0] second_start_y,
  input  logic signed [CW-1:0] second_end_x,
  input  logic signed [CW-1:0] second_end_y,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 hit,
  output logic signed [QW-1:0] first_param,
  output logic signed [QW-1:0] second_param,
  output logic signed [CW-1:0] cross_x,
  output logic signed [CW-1:0] cross_y,
  output logic signed [PW-1:0] direction_cross
);

  // stage map: 0..5 front end, 6 divider entry, 7..30 divider bits, 31 output
  localparam int FS = 6;
  localparam int NS = FS + QW + 2;

  logic [NS-1:0] v;
  logic [NS-1:0] en;

  // a stage takes new data when empty or when the one after it moves on
  always_comb begin
    en[NS-1] = !v[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // stage 0: direction and offset vectors
  logic signed [CW-1:0] s1_ax, s1_ay;
  logic signed [VW-1:0] s1_bx, s1_by, s1_dx, s1_dy, s1_ex, s1_ey;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_ax <= first_start_x;
      s1_ay <= first_start_y;
      s1_bx <= VW'(first_end_x) - VW'(first_start_x);
      s1_by <= VW'(first_end_y) - VW'(first_start_y);
      s1_dx <= VW'(second_end_x) - VW'(second_start_x);
      s1_dy <= VW'(second_end_y) - VW'(second_start_y);
      s1_ex <= VW'(second_start_x) - VW'(first_start_x);
      s1_ey <= VW'(second_start_y) - VW'(first_start_y);
    end
  end

  // stage 1: six cross product terms
  logic signed [CW-1:0] s2_ax, s2_ay;
  logic signed [VW-1:0] s2_bx, s2_by;
  logic signed [PW-1:0] s2_bxdy, s2_bydx, s2_exdy, s2_eydx, s2_exby, s2_eybx;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_ax   <= s1_ax;
      s2_ay   <= s1_ay;
      s2_bx   <= s1_bx;
      s2_by   <= s1_by;
      s2_bxdy <= s1_bx * s1_dy;
      s2_bydx <= s1_by * s1_dx;
      s2_exdy <= s1_ex * s1_dy;
      s2_eydx <= s1_ey * s1_dx;
      s2_exby <= s1_ex * s1_by;
      s2_eybx <= s1_ey * s1_bx;
    end
  end

  // stage 2: denominator and the two numerators
  logic signed [CW-1:0] s3_ax, s3_ay;
  logic signed [VW-1:0] s3_bx, s3_by;
  logic signed [PW-1:0] s3_den, s3_nt, s3_nu;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_ax  <= s2_ax;
      s3_ay  <= s2_ay;
      s3_bx  <= s2_bx;
      s3_by  <= s2_by;
      s3_den <= s2_bxdy - s2_bydx;
      s3_nt  <= s2_exdy - s2_eydx;
      s3_nu  <= s2_exby - s2_eybx;
    end
  end

  // stage 3: magnitudes, quotient signs, exact hit test on the ratios
  logic signed [CW-1:0] s4_ax, s4_ay;
  logic signed [PW-1:0] s4_den;
  logic                 s4_hit, s4_zero;
  logic [PW-1:0]        s4_dmag, s4_ntm, s4_num;
  logic [VW-1:0]        s4_bxm, s4_bym;
  logic [NDIV-1:0]      s4_neg;
  logic                 hit_t, hit_u;

  always_comb begin
    if (s3_den > 0) begin
      hit_t = (s3_nt >= 0) && (s3_nt <= s3_den);
      hit_u = (s3_nu >= 0) && (s3_nu <= s3_den);
    end else begin
      hit_t = (s3_nt <= 0) && (s3_nt >= s3_den);
      hit_u = (s3_nu <= 0) && (s3_nu >= s3_den);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_ax      <= s3_ax;
      s4_ay      <= s3_ay;
      s4_den     <= s3_den;
      s4_zero    <= (s3_den == '0);
      s4_hit     <= (s3_den != '0) && hit_t && hit_u;
      s4_dmag    <= s3_den[PW-1] ? PW'(-s3_den) : PW'(s3_den);
      s4_ntm     <= s3_nt[PW-1] ? PW'(-s3_nt) : PW'(s3_nt);
      s4_num     <= s3_nu[PW-1] ? PW'(-s3_nu) : PW'(s3_nu);
      s4_bxm     <= s3_bx[VW-1] ? VW'(-s3_bx) : VW'(s3_bx);
      s4_bym     <= s3_by[VW-1] ? VW'(-s3_by) : VW'(s3_by);
      s4_neg[DT] <= s3_nt[PW-1] ^ s3_den[PW-1];
      s4_neg[DU] <= s3_nu[PW-1] ^ s3_den[PW-1];
      s4_neg[DX] <= s3_bx[VW-1] ^ s3_nt[PW-1] ^ s3_den[PW-1];
      s4_neg[DY] <= s3_by[VW-1] ^ s3_nt[PW-1] ^ s3_den[PW-1];
    end
  end

  // stage 4: partial products of direction times first numerator
  logic signed [CW-1:0] s5_ax, s5_ay;
  logic signed [PW-1:0] s5_den;
  logic                 s5_hit, s5_zero;
  logic [PW-1:0]        s5_dmag;
  logic [NDIV-1:0]      s5_neg;
  logic [NW-1:0]        s5_nt, s5_nu;
  logic [PW-1:0]        s5_xlo, s5_xhi, s5_ylo, s5_yhi;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_ax   <= s4_ax;
      s5_ay   <= s4_ay;
      s5_den  <= s4_den;
      s5_hit  <= s4_hit;
      s5_zero <= s4_zero;
      s5_dmag <= s4_dmag;
      s5_neg  <= s4_neg;
      s5_nt   <= NW'({s4_ntm, {FRW{1'b0}}});
      s5_nu   <= NW'({s4_num, {FRW{1'b0}}});
      s5_xlo  <= s4_bxm * s4_ntm[VW-1:0];
      s5_xhi  <= s4_bxm * PW'(s4_ntm[PW-1:VW]);
      s5_ylo  <= s4_bym * s4_ntm[VW-1:0];
      s5_yhi  <= s4_bym * PW'(s4_ntm[PW-1:VW]);
    end
  end

  // stage 5: full point dividends
  logic signed [CW-1:0]    s6_ax, s6_ay;
  logic signed [PW-1:0]    s6_den;
  logic                    s6_hit, s6_zero;
  logic [PW-1:0]           s6_dmag;
  logic [NDIV-1:0]         s6_neg;
  logic [NDIV-1:0][NW-1:0] s6_n;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_ax     <= s5_ax;
      s6_ay     <= s5_ay;
      s6_den    <= s5_den;
      s6_hit    <= s5_hit;
      s6_zero   <= s5_zero;
      s6_dmag   <= s5_dmag;
      s6_neg    <= s5_neg;
      s6_n[DT]  <= s5_nt;
      s6_n[DU]  <= s5_nu;
      s6_n[DX]  <= NW'(s5_xlo) + NW'({s5_xhi, {VW{1'b0}}});
      s6_n[DY]  <= NW'(s5_ylo) + NW'({s5_yhi, {VW{1'b0}}});
    end
  end

  // divider entry: flag quotients that do not fit in QW bits
  div_t dv [0:QW];

  always_ff @(posedge clk) begin
    if (en[FS]) begin
      dv[0].ax   <= s6_ax;
      dv[0].ay   <= s6_ay;
      dv[0].den  <= s6_den;
      dv[0].hit  <= s6_hit;
      dv[0].zero <= s6_zero;
      dv[0].dmag <= s6_dmag;
      dv[0].neg  <= s6_neg;
      dv[0].rem  <= s6_n;
      dv[0].quo  <= '0;
      for (int j = 0; j < NDIV; j++) begin
        dv[0].ovf[j] <= ({{(QW+PW-NW){1'b0}}, s6_n[j]} >= {s6_dmag, {QW{1'b0}}});
      end
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 1; k <= QW; k++) begin : g_div
    localparam int SH = QW - k;
    div_t          nx;
    logic [RW-1:0] dsh;

    always_comb begin
      nx  = dv[k-1];
      dsh = RW'(dv[k-1].dmag) << SH;
      for (int j = 0; j < NDIV; j++) begin
        if (RW'(dv[k-1].rem[j]) >= dsh) begin
          nx.rem[j]     = NW'(RW'(dv[k-1].rem[j]) - dsh);
          nx.quo[j][SH] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[FS+k]) begin
        dv[k] <= nx;
      end
    end
  end

  // output stage: sign, saturation, point sum, parallel case
  logic signed [QW-1:0] par_next [0:1];
  logic signed [CW-1:0] pt_next  [0:1];
  logic signed [SW-1:0] psum     [0:1];
  logic signed [SW-1:0] qs       [0:1];

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      if (dv[QW].zero) begin
        par_next[j] = '0;
      end else if (dv[QW].ovf[j] || dv[QW].quo[j][QW-1]) begin
        par_next[j] = dv[QW].neg[j] ? PMIN : PMAX;
      end else if (dv[QW].neg[j]) begin
        par_next[j] = -$signed(dv[QW].quo[j]);
      end else begin
        par_next[j] = $signed(dv[QW].quo[j]);
      end
    end
    for (int j = 0; j < 2; j++) begin
      qs[j]   = $signed(SW'(dv[QW].quo[DX+j]));
      if (dv[QW].neg[DX+j]) begin
        qs[j] = -qs[j];
      end
      psum[j] = SW'(j == 0 ? dv[QW].ax : dv[QW].ay) + qs[j];
      if (dv[QW].zero) begin
        pt_next[j] = (j == 0) ? dv[QW].ax : dv[QW].ay;
      end else if (dv[QW].ovf[DX+j]) begin
        pt_next[j] = dv[QW].neg[DX+j] ? CMIN : CMAX;
      end else if (psum[j] > SW'(CMAX)) begin
        pt_next[j] = CMAX;
      end else if (psum[j] < SW'(CMIN)) begin
        pt_next[j] = CMIN;
      end else begin
        pt_next[j] = psum[j][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      hit             <= dv[QW].hit;
      first_param     <= par_next[0];
      second_param    <= par_next[1];
      cross_x         <= pt_next[0];
      cross_y         <= pt_next[1];
      direction_cross <= dv[QW].den;
    end
  end

endmodule
